### sv/boot_health_supervisor_defines.svh
// Assertion macros for the boot health supervisor.
// Included by the modules that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef BOOT_HEALTH_SUPERVISOR_DEFINES_SVH
`define BOOT_HEALTH_SUPERVISOR_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define BHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define BHS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### sv/bhs_pkg.sv
// Shared constants and types for the boot health supervisor.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package bhs_pkg;

  localparam int unsigned ROLE_COUNT_DEF = 3;

  localparam logic [3:0] KIND_BOOT     = 4'd0;
  localparam logic [3:0] KIND_FAILURE  = 4'd1;
  localparam logic [3:0] KIND_HEALTH   = 4'd2;
  localparam logic [3:0] KIND_BEGIN    = 4'd3;
  localparam logic [3:0] KIND_FEED     = 4'd4;
  localparam logic [3:0] KIND_END      = 4'd5;
  localparam logic [3:0] KIND_USB      = 4'd6;
  localparam logic [3:0] KIND_HANDOFF  = 4'd7;
  localparam logic [3:0] KIND_DEGRADED = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ARG   = 2'd1;
  localparam logic [1:0] ST_STATE = 2'd2;
  localparam logic [1:0] ST_EXT   = 2'd3;

  localparam logic [1:0] CAUSE_POWER = 2'd0;
  localparam logic [1:0] CAUSE_FAULT = 2'd1;

  localparam logic [1:0] CFG_FAILURE_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_STABLE_PERIOD   = 2'd1;
  localparam logic [1:0] CFG_PROGRESS_WINDOW = 2'd2;

  localparam logic [3:0]  FAILURE_LIMIT_RST   = 4'd2;
  localparam logic [31:0] STABLE_PERIOD_RST   = 32'd60000;
  localparam logic [31:0] PROGRESS_WINDOW_RST = 32'd5000;

  localparam logic [7:0] ERR_NONE    = 8'd0;
  localparam logic [7:0] ERR_TIMEOUT = 8'd255;

  typedef struct packed {
    logic load;
    logic commit;
  } bhs_cmd_t;

endpackage

### sv/bhs_ctrl.sv
// Controller of the boot health supervisor: input capture, evaluation step, result hold.
// Uses bhs_pkg and the assertion macros of boot_health_supervisor_defines.svh.
`timescale 1ns / 1ps
`include "boot_health_supervisor_defines.svh"

module bhs_ctrl
  import bhs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bhs_cmd_t cmd_o
);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EXEC = 1'b1;

  logic [0:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    in_ready_o   = (state_q == S_IDLE);
    cmd_o.load   = in_valid_i && (state_q == S_IDLE);
    cmd_o.commit = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.load) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_o.commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `BHS_ASSERT(a_accept_starts_exec, (in_valid_i && in_ready_o) |=> (state_q == S_EXEC), "accepted transfer did not start evaluation")
  `BHS_ASSERT(a_no_result_overwrite, cmd_o.commit |-> (!out_valid_q || out_ready_i), "result overwritten before its transfer")
  `BHS_ASSERT(a_commit_shows_result, cmd_o.commit |=> (out_valid_q && (state_q == S_IDLE)), "evaluated result not offered")
  `BHS_ASSERT_NEVER(a_load_commit_excl, cmd_o.load && cmd_o.commit, "capture and evaluation in the same cycle")

endmodule

### sv/bhs_dpath.sv
// Datapath of the boot health supervisor: configuration, retained record, role table, result.
// Uses bhs_pkg; driven by the command struct of bhs_ctrl.
`timescale 1ns / 1ps

module bhs_dpath
  import bhs_pkg::*;
#(
  parameter int unsigned ROLE_COUNT = ROLE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bhs_cmd_t    cmd_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [3:0]  kind_i,
  input  logic [1:0]  reset_cause_i,
  input  logic        record_intact_i,
  input  logic [2:0]  role_i,
  input  logic [7:0]  caller_id_i,
  input  logic [31:0] now_ms_i,
  input  logic        healthy_i,
  input  logic [7:0]  error_code_i,
  input  logic        external_ok_i,
  output logic [1:0]  status_o,
  output logic [3:0]  failure_count_o,
  output logic        maintenance_required_o,
  output logic        boot_live_o,
  output logic [7:0]  recent_err_o,
  output logic        handoff_granted_o,
  output logic        startup_watchdog_off_o
);

  localparam int unsigned RIW = $clog2(ROLE_COUNT);

  logic [3:0]  limit_q;
  logic [31:0] period_q, window_q;

  logic [3:0]  kind_q;
  logic [1:0]  cause_q;
  logic        intact_q, healthy_q, ok_q;
  logic [2:0]  role_q;
  logic [7:0]  caller_q, errc_q;
  logic [31:0] now_q;

  logic        started_q, started_d;
  logic [3:0]  failures_q, failures_d;
  logic        boot_live_q, boot_live_d;
  logic        fail_seen_q, fail_seen_d;
  logic [7:0]  err_q, err_d;
  logic        stage_set_q, stage_set_d;
  logic        stable_run_q, stable_run_d;
  logic [31:0] stable_start_q, stable_start_d;
  logic        usb_fin_q, usb_fin_d;
  logic        usb_ok_q, usb_ok_d;
  logic        handed_off_q, handed_off_d;
  logic [1:0]  status_q, status_d;
  logic        granted_q, granted_d;

  logic [ROLE_COUNT-1:0] owned_q, owned_d, prog_q, prog_d;
  logic [7:0]            owner_q [ROLE_COUNT];
  logic [7:0]            owner_d [ROLE_COUNT];
  logic [31:0]           at_q    [ROLE_COUNT];
  logic [31:0]           at_d    [ROLE_COUNT];

  logic [ROLE_COUNT-1:0] hit, fresh;
  logic [RIW-1:0]        tgt;
  logic                  role_ok, tgt_owned, tgt_mine, caller_busy, claim_free;
  logic                  do_claim, do_feed, do_end;
  logic [31:0]           start_sel;

  always_comb begin
    role_ok = ({1'b0, role_q} < 4'(ROLE_COUNT));
    tgt     = (kind_q == KIND_BOOT) ? '0 : role_q[RIW-1:0];

    tgt_owned   = 1'b0;
    tgt_mine    = 1'b0;
    caller_busy = 1'b0;
    for (int i = 0; i < ROLE_COUNT; i++) begin
      hit[i]      = (RIW'(i) == tgt);
      tgt_owned   = tgt_owned | (hit[i] & owned_q[i]);
      tgt_mine    = tgt_mine | (hit[i] & owned_q[i] & (owner_q[i] == caller_q));
      caller_busy = caller_busy | (owned_q[i] & (owner_q[i] == caller_q));
      fresh[i]    = owned_q[i] & prog_q[i] &
                    (((now_q - at_q[i]) <= window_q) || ((at_q[i] - now_q) <= window_q));
    end
    claim_free = !(tgt_owned || caller_busy);

    started_d      = started_q;
    failures_d     = failures_q;
    boot_live_d    = boot_live_q;
    fail_seen_d    = fail_seen_q;
    err_d          = err_q;
    stage_set_d    = stage_set_q;
    stable_run_d   = stable_run_q;
    stable_start_d = stable_start_q;
    usb_fin_d      = usb_fin_q;
    usb_ok_d       = usb_ok_q;
    handed_off_d   = handed_off_q;
    status_d       = ST_OK;
    granted_d      = 1'b0;
    do_claim       = 1'b0;
    do_feed        = 1'b0;
    do_end         = 1'b0;
    start_sel      = stable_run_q ? stable_start_q : now_q;

    unique case (kind_q)
      KIND_BOOT: begin
        if (started_q) begin
          status_d = ST_STATE;
        end else begin
          if ((cause_q == CAUSE_POWER) || !intact_q) begin
            failures_d  = 4'd0;
            err_d       = ERR_NONE;
            stage_set_d = 1'b0;
          end else if ((boot_live_q || (cause_q == CAUSE_FAULT)) &&
                       (failures_q < limit_q)) begin
            failures_d = failures_q + 4'd1;
            if (!stage_set_q) begin
              err_d       = ERR_TIMEOUT;
              stage_set_d = 1'b1;
            end
          end
          boot_live_d = 1'b1;
          started_d   = 1'b1;
          do_claim    = 1'b1;
          status_d    = !claim_free ? ST_STATE : (ok_q ? ST_OK : ST_EXT);
        end
      end
      KIND_FAILURE: begin
        if (!fail_seen_q && (failures_q < limit_q)) begin
          failures_d = failures_q + 4'd1;
        end
        fail_seen_d = 1'b1;
        boot_live_d = 1'b0;
        err_d       = errc_q;
        stage_set_d = 1'b1;
      end
      KIND_HEALTH: begin
        if (!healthy_q) begin
          stable_run_d = 1'b0;
        end else begin
          stable_run_d   = 1'b1;
          stable_start_d = start_sel;
          if (((now_q - start_sel) >= period_q) && !fail_seen_q &&
              ((failures_q != 4'd0) || boot_live_q)) begin
            failures_d  = 4'd0;
            boot_live_d = 1'b0;
            err_d       = ERR_NONE;
            stage_set_d = 1'b0;
          end
        end
      end
      KIND_BEGIN: begin
        if (!started_q || !role_ok) begin
          status_d = ST_ARG;
        end else begin
          do_claim = 1'b1;
          status_d = !claim_free ? ST_STATE : (ok_q ? ST_OK : ST_EXT);
        end
      end
      KIND_FEED, KIND_END: begin
        if (!role_ok) begin
          status_d = ST_ARG;
        end else if (!tgt_mine) begin
          status_d = ST_STATE;
        end else if (!ok_q) begin
          status_d = ST_EXT;
        end else begin
          do_feed = (kind_q == KIND_FEED);
          do_end  = (kind_q == KIND_END);
        end
      end
      KIND_USB: begin
        usb_fin_d = 1'b1;
        usb_ok_d  = ok_q;
      end
      KIND_HANDOFF: begin
        granted_d = usb_fin_q && usb_ok_q && (&fresh);
        if (granted_d) begin
          handed_off_d = 1'b1;
        end
      end
      KIND_DEGRADED: begin
        granted_d = fail_seen_q && fresh[0];
        if (granted_d) begin
          handed_off_d = 1'b1;
        end
      end
      default: begin
        status_d = ST_ARG;
      end
    endcase

    for (int i = 0; i < ROLE_COUNT; i++) begin
      owned_d[i] = owned_q[i];
      prog_d[i]  = prog_q[i];
      owner_d[i] = owner_q[i];
      at_d[i]    = at_q[i];
      if (hit[i]) begin
        if ((do_claim && claim_free && !ok_q) || do_end) begin
          owned_d[i] = 1'b0;
          prog_d[i]  = 1'b0;
          owner_d[i] = '0;
          at_d[i]    = '0;
        end else if (do_claim && claim_free) begin
          owned_d[i] = 1'b1;
          owner_d[i] = caller_q;
        end else if (do_feed) begin
          prog_d[i] = 1'b1;
          at_d[i]   = now_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= FAILURE_LIMIT_RST;
      period_q <= STABLE_PERIOD_RST;
      window_q <= PROGRESS_WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FAILURE_LIMIT:   limit_q  <= cfg_data_i[3:0];
        CFG_STABLE_PERIOD:   period_q <= cfg_data_i;
        CFG_PROGRESS_WINDOW: window_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= kind_i;
      cause_q   <= reset_cause_i;
      intact_q  <= record_intact_i;
      role_q    <= role_i;
      caller_q  <= caller_id_i;
      now_q     <= now_ms_i;
      healthy_q <= healthy_i;
      errc_q    <= error_code_i;
      ok_q      <= external_ok_i;
    end
    if (cmd_i.commit) begin
      status_q  <= status_d;
      granted_q <= granted_d;
      for (int i = 0; i < ROLE_COUNT; i++) begin
        owner_q[i] <= owner_d[i];
        at_q[i]    <= at_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q      <= 1'b0;
      failures_q     <= 4'd0;
      boot_live_q    <= 1'b0;
      fail_seen_q    <= 1'b0;
      err_q          <= ERR_NONE;
      stage_set_q    <= 1'b0;
      stable_run_q   <= 1'b0;
      stable_start_q <= '0;
      usb_fin_q      <= 1'b0;
      usb_ok_q       <= 1'b0;
      handed_off_q   <= 1'b0;
      owned_q        <= '0;
      prog_q         <= '0;
    end else if (cmd_i.commit) begin
      started_q      <= started_d;
      failures_q     <= failures_d;
      boot_live_q    <= boot_live_d;
      fail_seen_q    <= fail_seen_d;
      err_q          <= err_d;
      stage_set_q    <= stage_set_d;
      stable_run_q   <= stable_run_d;
      stable_start_q <= stable_start_d;
      usb_fin_q      <= usb_fin_d;
      usb_ok_q       <= usb_ok_d;
      handed_off_q   <= handed_off_d;
      owned_q        <= owned_d;
      prog_q         <= prog_d;
    end
  end

  assign status_o               = status_q;
  assign failure_count_o        = failures_q;
  assign maintenance_required_o = (failures_q >= limit_q);
  assign boot_live_o            = boot_live_q;
  assign recent_err_o           = err_q;
  assign handoff_granted_o      = granted_q;
  assign startup_watchdog_off_o = handed_off_q;

endmodule

### sv/boot_health_supervisor.sv
// Top level of the boot health supervisor: event channel, result channel, configuration port.
// Instantiates bhs_ctrl and bhs_dpath; uses bhs_pkg.
//
//   Channel   Handshake                    Carries
//   event     in_valid_i / in_ready_o      kind, cause, intact, role, caller, time, flags
//   result    out_valid_o / out_ready_i    status, count, flags, last error, handoff
//   config    cfg_we_i (no wait)           index cfg_idx_i, data cfg_data_i
//
// An event is first captured, then evaluated in the datapath.
// The block takes no new event until the current one has been evaluated.
// While a result waits in the output register one further event is captured;
// its evaluation holds until the waiting result has been transferred.
// Reset clears the record, role ownership and handoff state and restores configuration defaults.
`timescale 1ns / 1ps

module boot_health_supervisor
  import bhs_pkg::*;
#(
  parameter int unsigned ROLE_COUNT = ROLE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  kind_i,
  input  logic [1:0]  reset_cause_i,
  input  logic        record_intact_i,
  input  logic [2:0]  role_i,
  input  logic [7:0]  caller_id_i,
  input  logic [31:0] now_ms_i,
  input  logic        healthy_i,
  input  logic [7:0]  error_code_i,
  input  logic        external_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  failure_count_o,
  output logic        maintenance_required_o,
  output logic        boot_live_o,
  output logic [7:0]  recent_err_o,
  output logic        handoff_granted_o,
  output logic        startup_watchdog_off_o
);

  bhs_cmd_t cmd;

  bhs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  bhs_dpath #(
    .ROLE_COUNT (ROLE_COUNT)
  ) u_dpath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .kind_i                 (kind_i),
    .reset_cause_i          (reset_cause_i),
    .record_intact_i        (record_intact_i),
    .role_i                 (role_i),
    .caller_id_i            (caller_id_i),
    .now_ms_i               (now_ms_i),
    .healthy_i              (healthy_i),
    .error_code_i           (error_code_i),
    .external_ok_i          (external_ok_i),
    .status_o               (status_o),
    .failure_count_o        (failure_count_o),
    .maintenance_required_o (maintenance_required_o),
    .boot_live_o            (boot_live_o),
    .recent_err_o           (recent_err_o),
    .handoff_granted_o      (handoff_granted_o),
    .startup_watchdog_off_o (startup_watchdog_off_o)
  );

endmodule
